@@ rtl/sup_pkg.sv @@
// Types and codes shared by the sorted unique priority queue modules.
package sup_pkg;

  localparam int KEY_W = 31;

  typedef enum logic [1:0] {
    OP_INSERT     = 2'd0,
    OP_REMOVE_MIN = 2'd1,
    OP_REMOVE_KEY = 2'd2,
    OP_QUERY      = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_INVALID  = 2'd1,
    ST_REPEATED = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  // Action every cell takes on the current request.
  typedef enum logic [1:0] {
    CELL_HOLD      = 2'd0,
    CELL_INSERT    = 2'd1,
    CELL_SHIFT_GE  = 2'd2,
    CELL_SHIFT_ALL = 2'd3
  } cell_op_t;

  typedef struct packed {
    cell_op_t           op;
    logic [KEY_W-1:0]   key;
  } cell_cmd_t;

endpackage

@@ rtl/sorted_unique_priority_queue_top.sv @@
// Sorted unique priority queue: request decode, cell chain and result register.
//
// Usage:
//   Requests enter on in_valid/in_ready with in_opcode and in_key; each request
//   yields exactly one result on out_valid/out_ready carrying status, found,
//   count, head key and empty flag as they stand after the operation.
//   Keys live in a row of DEPTH cells kept in ascending order. Every cell
//   compares its key with the request key in the same cycle; insert shifts the
//   cells at and above the insert point one place up, removes shift them down.
//   The result is registered and shows in the cycle after acceptance.
//   Throughput: one request per cycle unless stalled; the single compare-and-shift pass
//   through the chain plus the OR over all match flags sets the cycle.
//   A stalled result holds in the output register; a new request is taken in
//   the cycle the held result leaves, so nothing is lost while stalled.
//   cfg_we writes the exclusive key limit at once; write it only while idle.
//   Synchronous reset empties the queue, clears the output valid and sets the
//   key limit to 1000000000. No clearing pass is needed.
module sorted_unique_priority_queue_top #(
  parameter int DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [sup_pkg::KEY_W-1:0]        cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [1:0]                       in_opcode,
  input  logic signed [31:0]               in_key,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [1:0]                       out_status,
  output logic                             out_found,
  output logic [$clog2(DEPTH+1)-1:0]       out_count,
  output logic [sup_pkg::KEY_W-1:0]        out_head_key,
  output logic                             out_is_empty
);
  import sup_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [KEY_W-1:0] key_limit_r;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             out_valid_r;
  logic [1:0]       status_r;
  logic             found_r;
  logic [KEY_W-1:0] head_r;
  logic             in_fire;

  logic [KEY_W-1:0] cell_key [DEPTH];
  logic [KEY_W-1:0] cell_key_nxt [DEPTH];
  logic [DEPTH-1:0] cell_valid, cell_valid_nxt, cell_less, cell_match;

  cell_cmd_t        cmd;
  opcode_t          opcode;
  logic [KEY_W-1:0] key_low;
  logic             key_neg, key_ok, found_key, full;
  status_t          status_nxt;
  logic             found_nxt;

  assign opcode  = opcode_t'(in_opcode);
  assign key_low = in_key[KEY_W-1:0];
  assign key_neg = in_key[31];
  assign key_ok  = !key_neg && (key_low != '0) && (key_low < key_limit_r);

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  assign found_key = !key_neg && (|cell_match);
  assign full      = cell_valid[DEPTH-1];

  // Decode the request into one chain action.
  always_comb begin
    cmd.key    = key_low;
    cmd.op     = CELL_HOLD;
    status_nxt = ST_OK;
    found_nxt  = found_key;
    count_nxt  = count_r;
    case (opcode)
      OP_INSERT: begin
        if (!key_ok) begin
          status_nxt = ST_INVALID;
        end else if (found_key) begin
          status_nxt = ST_REPEATED;
        end else if (full) begin
          status_nxt = ST_FULL;
        end else begin
          cmd.op    = CELL_INSERT;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      OP_REMOVE_MIN: begin
        found_nxt = cell_valid[0];
        if (cell_valid[0]) begin
          cmd.op    = CELL_SHIFT_ALL;
          count_nxt = count_r - CNT_W'(1);
        end
      end
      OP_REMOVE_KEY: begin
        if (found_key) begin
          cmd.op    = CELL_SHIFT_GE;
          count_nxt = count_r - CNT_W'(1);
        end
      end
      default: begin
        cmd.op = CELL_HOLD;
      end
    endcase
    if (!in_fire) begin
      cmd.op    = CELL_HOLD;
      count_nxt = count_r;
    end
  end

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      logic             l_less, l_valid, r_valid;
      logic [KEY_W-1:0] l_key, r_key;
      if (gi == 0) begin : g_first
        assign l_less  = 1'b1;
        assign l_key   = '0;
        assign l_valid = 1'b0;
      end else begin : g_mid
        assign l_less  = cell_less[gi-1];
        assign l_key   = cell_key[gi-1];
        assign l_valid = cell_valid[gi-1];
      end
      if (gi == DEPTH - 1) begin : g_last
        assign r_key   = '0;
        assign r_valid = 1'b0;
      end else begin : g_inner
        assign r_key   = cell_key[gi+1];
        assign r_valid = cell_valid[gi+1];
      end
      sup_cell u_cell (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .left_less   (l_less),
        .left_key    (l_key),
        .left_valid  (l_valid),
        .right_key   (r_key),
        .right_valid (r_valid),
        .key_r       (cell_key[gi]),
        .valid_r     (cell_valid[gi]),
        .less        (cell_less[gi]),
        .match       (cell_match[gi]),
        .key_nxt     (cell_key_nxt[gi]),
        .valid_nxt   (cell_valid_nxt[gi])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_limit_r <= KEY_W'(1000000000);
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        key_limit_r <= cfg_data;
      end
      count_r <= count_nxt;
      if (in_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Capture the result from the chain's next state.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      status_r <= status_nxt;
      found_r  <= found_nxt;
      head_r   <= cell_valid_nxt[0] ? cell_key_nxt[0] : '0;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_status   = status_r;
  assign out_found    = found_r;
  assign out_count    = count_r;
  assign out_head_key = head_r;
  assign out_is_empty = (count_r == '0);

  // Occupied cells always form a prefix of the chain.
  a_valid_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    ((cell_valid + DEPTH'(1)) & cell_valid) == '0)
    else $error("occupied cells are not contiguous");

  a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(cell_valid) == int'(count_r))
    else $error("entry count disagrees with occupied cells");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_valid_r)
    else $error("accepted request produced no result");

  a_empty_head: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_is_empty) |-> (out_head_key == '0))
    else $error("empty queue reports a nonzero head key");

endmodule

@@ rtl/sup_cell.sv @@
// One slot of the sorted chain: holds a key, compares it and shifts left or right.
module sup_cell (
  input  logic                     clk,
  input  logic                     rst_n,
  input  sup_pkg::cell_cmd_t       cmd,
  input  logic                     left_less,
  input  logic [sup_pkg::KEY_W-1:0] left_key,
  input  logic                     left_valid,
  input  logic [sup_pkg::KEY_W-1:0] right_key,
  input  logic                     right_valid,
  output logic [sup_pkg::KEY_W-1:0] key_r,
  output logic                     valid_r,
  output logic                     less,
  output logic                     match,
  output logic [sup_pkg::KEY_W-1:0] key_nxt,
  output logic                     valid_nxt
);
  import sup_pkg::*;

  assign less  = valid_r && (key_r < cmd.key);
  assign match = valid_r && (key_r == cmd.key);

  always_comb begin
    key_nxt   = key_r;
    valid_nxt = valid_r;
    case (cmd.op)
      CELL_INSERT: begin
        if (!less) begin
          if (left_less) begin
            key_nxt   = cmd.key;
            valid_nxt = 1'b1;
          end else begin
            key_nxt   = left_key;
            valid_nxt = left_valid;
          end
        end
      end
      CELL_SHIFT_GE: begin
        if (!less) begin
          key_nxt   = right_key;
          valid_nxt = right_valid;
        end
      end
      CELL_SHIFT_ALL: begin
        key_nxt   = right_key;
        valid_nxt = right_valid;
      end
      default: begin
        key_nxt   = key_r;
        valid_nxt = valid_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

endmodule
